// File: rtl/core/qbso_pkg.sv
// ----------------------------------------------------------------------------
// Quasi-bandlimited sawtooth oscillator package
// Shared constants, command and status types, and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package qbso_pkg;

  localparam int SineTableBits = 10;
  localparam int SampleBits    = 24;
  localparam int FracBits      = SampleBits - 5;

  localparam int FreqBits   = 24;
  localparam int TimbreBits = 17;
  localparam int DiffBits   = 25;
  localparam int GainBits   = 26;
  localparam int CycleBits  = 25;

  localparam int TableSize = 1 << SineTableBits;
  localparam int SineW     = FracBits + 1;

  localparam int SumW = SampleBits + 4;
  localparam int MulW = (SumW > GainBits) ? SumW : GainBits;

  // Division by one thousand splits into a shift by three and a division by
  // 125, done as a multiplication by a rounded-up reciprocal.
  localparam int DivW          = FracBits + 10;
  localparam int DivPreShift   = 3;
  localparam int DivOdd        = 125;
  localparam int DivNumW       = DivW - DivPreShift;
  localparam int DivRecipShift = DivNumW + 7;
  localparam int DivRecipW     = DivNumW + 1;

  localparam logic [63:0] DivRecip = ((64'd1 << DivRecipShift) + 64'(DivOdd) - 64'd1)
                                     / 64'(DivOdd);

  localparam logic [63:0] C376   = ((64'd376 << FracBits) + 64'd500) / 64'd1000;
  localparam logic [63:0] PiQ30  = 64'd3373259426;
  localparam logic [63:0] OneQ30 = 64'd1 << 30;

  typedef logic [TableSize-1:0][SineW-1:0] sine_table_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DD,
    MUL_D2,
    MUL_AMT,
    MUL_FB,
    MUL_OUT
  } mul_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ1,
    S_SQ2,
    S_AMT,
    S_FB,
    S_SINE,
    S_FILT,
    S_WAIT,
    S_SCALE,
    S_OUT
  } state_e;

  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    logic     sine_rd;
    logic     z_upd;
    logic     sum_upd;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_status_t;

  // Each entry holds the sine at the center of its slot of the first quadrant,
  // evaluated by a Taylor series to the fifteenth power in Q2.30.
  function automatic sine_table_t build_sine_table();
    sine_table_t tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    for (int i = 0; i < TableSize; i++) begin
      x  = (PiQ30 * 64'(2 * i + 1)) >> (SineTableBits + 2);
      x2 = (x * x) >> 30;
      t  = OneQ30;
      t  = OneQ30 - (((x2 * t) >> 30) / 64'd210);
      t  = OneQ30 - (((x2 * t) >> 30) / 64'd156);
      t  = OneQ30 - (((x2 * t) >> 30) / 64'd110);
      t  = OneQ30 - (((x2 * t) >> 30) / 64'd72);
      t  = OneQ30 - (((x2 * t) >> 30) / 64'd42);
      t  = OneQ30 - (((x2 * t) >> 30) / 64'd20);
      t  = OneQ30 - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      tbl[i] = SineW'((s + (64'd1 << (29 - FracBits))) >> (30 - FracBits));
    end
    return tbl;
  endfunction

endpackage

// File: rtl/core/qbso_sine_rom.sv
// ----------------------------------------------------------------------------
// Quarter-wave sine ROM
// Synchronous read of the first-quadrant sine table.
// ----------------------------------------------------------------------------
module qbso_sine_rom
  import qbso_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [SineTableBits-1:0] addr_i,
  output logic [SineW-1:0]         data_o
);

  localparam sine_table_t SineTable = build_sine_table();

  logic [SineW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= SineTable[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// File: rtl/core/qbso_const_div.sv
// ----------------------------------------------------------------------------
// Constant divider
// Division by one thousand through a reciprocal multiplication. The shifted
// dividend is registered at the start, and the quotient is registered from it.
// ----------------------------------------------------------------------------
module qbso_const_div
  import qbso_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DivW-1:0]     dividend_i,
  output logic                busy_o,
  output logic [FracBits-1:0] quot_o
);

  localparam int DivProdW = DivNumW + DivRecipW;
  localparam logic [DivRecipW-1:0] Recip = DivRecipW'(DivRecip);

  logic [DivNumW-1:0]  num_q;
  logic                pend_q;
  logic [FracBits-1:0] quot_q;
  logic [DivProdW-1:0] prod;

  assign prod = DivProdW'(num_q) * DivProdW'(Recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i[DivW-1:DivPreShift];
    end
    if (pend_q) begin
      quot_q <= prod[DivRecipShift +: FracBits];
    end
  end

  assign busy_o = pend_q;
  assign quot_o = quot_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !pend_q)
    else $error("Division started while the previous one was running.");

  a_busy_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> !pend_q)
    else $error("Division stayed busy for more than one cycle.");

  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ((prod >> (DivRecipShift + FracBits)) == '0))
    else $error("Division quotient does not fit its register.");

endmodule

// File: rtl/core/qbso_datapath.sv
// ----------------------------------------------------------------------------
// Oscillator datapath
// Phase accumulator, feedback state, shared multiplier, sine lookup and
// output scaling, sequenced by the controller's commands.
// ----------------------------------------------------------------------------
module qbso_datapath
  import qbso_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dp_cmd_t                      cmd_i,
  output dp_status_t                   status_o,
  input  logic [FreqBits-1:0]          norm_freq_i,
  input  logic [TimbreBits-1:0]        timbre_i,
  output logic signed [SampleBits-1:0] sample_o
);

  localparam int ProdW = 2 * MulW;
  localparam logic signed [ProdW-1:0] YMax = ProdW'((64'd1 << (SampleBits - 1)) - 64'd1);
  localparam logic signed [ProdW-1:0] YMin = -YMax - ProdW'(1);

  logic [FreqBits-1:0]          phase_q;
  logic signed [SampleBits-1:0] z0_q;
  logic signed [SampleBits-1:0] z1_q;
  logic [TimbreBits-1:0]        timbre_q;
  logic signed [DiffBits-1:0]   d_q;
  logic signed [GainBits-1:0]   gain_q;
  logic signed [ProdW-1:0]      p_q;
  logic signed [SumW-1:0]       sum_q;
  logic                         neg_q;
  logic signed [SampleBits-1:0] sample_q;

  logic signed [MulW-1:0]  mul_a;
  logic signed [MulW-1:0]  mul_b;
  logic signed [ProdW-1:0] prod;

  logic [22:0] d2;
  logic [20:0] d4;
  logic [23:0] amt13;
  logic [24:0] fb_amt;

  logic [33:0]          w752;
  logic [33+FracBits:0] w752_ext;
  logic [DivW-1:0]      dividend;
  logic                 div_busy;
  logic [FracBits-1:0]  wterm;

  logic [CycleBits-1:0]     bip;
  logic [CycleBits-1:0]     cyc;
  logic [SineTableBits-1:0] idx_raw;
  logic [SineTableBits-1:0] rom_addr;
  logic [SineW-1:0]         rom_data;

  logic signed [SampleBits-1:0] sine_pos;
  logic signed [SampleBits-1:0] sine_val;
  logic signed [SampleBits:0]   zsum;

  logic signed [SumW-1:0]  z0x;
  logic signed [SumW-1:0]  z1x;
  logic signed [SumW-1:0]  mix;
  logic signed [SumW-1:0]  mix_half;
  logic signed [SumW-1:0]  c376_s;
  logic signed [SumW-1:0]  wterm_s;
  logic signed [ProdW-1:0] y_full;

  assign d2     = p_q[46:24];
  assign d4     = p_q[44:24];
  assign amt13  = (24'(d4) << 3) + (24'(d4) << 2) + 24'(d4);
  assign fb_amt = p_q[40:16];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_DD: begin
        mul_a = MulW'(d_q);
        mul_b = MulW'(d_q);
      end
      MUL_D2: begin
        mul_a = MulW'({1'b0, d2});
        mul_b = MulW'({1'b0, d2});
      end
      MUL_AMT: begin
        mul_a = MulW'({1'b0, amt13});
        mul_b = MulW'({1'b0, timbre_q});
      end
      MUL_FB: begin
        mul_a = MulW'({1'b0, fb_amt});
        mul_b = MulW'(z0_q);
      end
      MUL_OUT: begin
        mul_a = MulW'(sum_q);
        mul_b = MulW'(gain_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign w752 = (34'(norm_freq_i) << 9) + (34'(norm_freq_i) << 7) + (34'(norm_freq_i) << 6)
              + (34'(norm_freq_i) << 5) + (34'(norm_freq_i) << 4);
  assign w752_ext = {w752, {FracBits{1'b0}}};
  assign dividend = w752_ext[33+FracBits:24];

  qbso_const_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.load_in),
    .dividend_i(dividend),
    .busy_o    (div_busy),
    .quot_o    (wterm)
  );

  assign bip      = {phase_q, 1'b0} + (CycleBits'(1) << 24);
  assign cyc      = bip + p_q[FracBits+24:FracBits];
  assign idx_raw  = cyc[22 -: SineTableBits];
  assign rom_addr = cyc[23] ? ~idx_raw : idx_raw;

  qbso_sine_rom u_rom (
    .clk_i  (clk_i),
    .rd_en_i(cmd_i.sine_rd),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign sine_pos = SampleBits'(rom_data);
  assign sine_val = neg_q ? -sine_pos : sine_pos;
  assign zsum     = (SampleBits + 1)'(z0_q) + (SampleBits + 1)'(sine_val);

  assign z0x      = SumW'(z0_q);
  assign z1x      = SumW'(z1_q);
  assign mix      = (z0x <<< 2) + z0x - ((z1x <<< 1) + z1x);
  assign mix_half = mix >>> 1;
  assign c376_s   = SumW'(C376);
  assign wterm_s  = SumW'(wterm);

  assign y_full = p_q >>> 24;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      z0_q    <= '0;
      z1_q    <= '0;
    end else begin
      if (cmd_i.load_in) begin
        phase_q <= phase_q + norm_freq_i;
      end
      if (cmd_i.z_upd) begin
        z0_q <= zsum[SampleBits:1];
      end
      if (cmd_i.sum_upd) begin
        z1_q <= z0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      timbre_q <= timbre_i;
      d_q      <= (DiffBits'(1) << 23) - DiffBits'(norm_freq_i);
      gain_q   <= (GainBits'(1) << 24) - {1'b0, norm_freq_i, 1'b0};
    end
    if (cmd_i.mul_sel != MUL_NONE) begin
      p_q <= prod;
    end
    if (cmd_i.sine_rd) begin
      neg_q <= cyc[24];
    end
    if (cmd_i.sum_upd) begin
      sum_q <= mix_half + c376_s - wterm_s;
    end
    if (cmd_i.out_load) begin
      if (y_full > YMax) begin
        sample_q <= YMax[SampleBits-1:0];
      end else if (y_full < YMin) begin
        sample_q <= YMin[SampleBits-1:0];
      end else begin
        sample_q <= y_full[SampleBits-1:0];
      end
    end
  end

  assign status_o.div_busy = div_busy;
  assign sample_o          = sample_q;

endmodule

// File: rtl/core/qbso_ctrl.sv
// ----------------------------------------------------------------------------
// Oscillator controller
// Steps the datapath through one sample and runs both handshakes.
// ----------------------------------------------------------------------------
module qbso_ctrl
  import qbso_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SQ1;
      S_SQ1:   state_d = S_SQ2;
      S_SQ2:   state_d = S_AMT;
      S_AMT:   state_d = S_FB;
      S_FB:    state_d = S_SINE;
      S_SINE:  state_d = S_FILT;
      S_FILT:  state_d = S_WAIT;
      S_WAIT:  if (!status_i.div_busy) state_d = S_SCALE;
      S_SCALE: state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_NONE;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_SQ1:   cmd_o.mul_sel = MUL_DD;
      S_SQ2:   cmd_o.mul_sel = MUL_D2;
      S_AMT:   cmd_o.mul_sel = MUL_AMT;
      S_FB:    cmd_o.mul_sel = MUL_FB;
      S_SINE:  cmd_o.sine_rd = 1'b1;
      S_FILT:  cmd_o.z_upd = 1'b1;
      S_WAIT:  cmd_o.sum_upd = !status_i.div_busy;
      S_SCALE: cmd_o.mul_sel = MUL_OUT;
      S_OUT:   cmd_o.out_load = out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_scale_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCALE) |-> !status_i.div_busy)
    else $error("Output scaling started before the frequency term was ready.");

  a_out_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("Result appeared outside the final step.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("Output sample dropped before its transfer.");

endmodule

// File: rtl/core/quasi_bandlimited_saw_osc.sv
// ----------------------------------------------------------------------------
// Quasi-bandlimited sawtooth oscillator
// One output sample per input transfer, from a phase accumulator and a
// sine-based feedback filter.
// ----------------------------------------------------------------------------
// Each input transfer yields one output sample. A new input is accepted only in
// the idle state, which is reached again once the output register is loaded.
// The steps after the transfer are these, in order: four products
// for the feedback amount and the sine phase offset on one shared registered
// multiplier, the sine table read, the feedback update, the mix with the 0.752*w
// correction, the output scaling product and the output register load. The
// correction is divided by one thousand through a reciprocal multiplication that
// is finished long before it is needed. The result sits in an output register,
// so the next input can be accepted while the previous sample still waits to be
// taken; that next item then holds at its final step until the register frees.
module quasi_bandlimited_saw_osc
  import qbso_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [FreqBits-1:0]          norm_freq_i,
  input  logic [TimbreBits-1:0]        timbre_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SampleBits-1:0] sample_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  qbso_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  qbso_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .norm_freq_i(norm_freq_i),
    .timbre_i   (timbre_i),
    .sample_o   (sample_o)
  );

endmodule

// File: bench/quasi_bandlimited_saw_osc_tb.sv
// ----------------------------------------------------------------------------
// Quasi-bandlimited sawtooth oscillator testbench
// Feeds tones of held and changing frequency and timbre through the oscillator,
// predicts every output sample in fixed point and compares it as it leaves.
// ----------------------------------------------------------------------------
import qbso_pkg::*;

class sample_scoreboard;

  longint quarter_sine [TableSize];
  longint phase;
  longint feedback_now;
  longint feedback_prev;
  logic signed [SampleBits-1:0] pending_samples [$];
  int mismatches;
  int samples_checked;

  function new();
    longint pi_q30;
    longint one_q30;
    longint x;
    longint x2;
    longint t;
    longint s;
    pi_q30  = 64'd3373259426;
    one_q30 = 64'sd1 <<< 30;
    for (int i = 0; i < TableSize; i++) begin
      x  = (pi_q30 * (2 * i + 1)) / (4 * TableSize);
      x2 = (x * x) >>> 30;
      t  = one_q30;
      for (int k = 14; k >= 2; k -= 2) begin
        t = one_q30 - ((x2 * t) >>> 30) / (k * (k + 1));
      end
      s = (x * t) >>> 30;
      quarter_sine[i] = (s + (64'sd1 <<< (29 - FracBits))) >>> (30 - FracBits);
    end
    phase = 0;
    feedback_now = 0;
    feedback_prev = 0;
    mismatches = 0;
    samples_checked = 0;
  endfunction

  function longint clamp(longint v);
    longint top;
    top = (64'sd1 <<< (SampleBits - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  function longint sine_of(longint arg);
    longint cyc;
    longint idx;
    longint quad;
    longint v;
    cyc  = arg & 64'h1FF_FFFF;
    quad = (cyc >> 23) & 3;
    idx  = (cyc >> (23 - SineTableBits)) & (TableSize - 1);
    if (quad & 1) idx = TableSize - 1 - idx;
    v = quarter_sine[idx];
    return (quad & 2) ? -v : v;
  endfunction

  function void accept_tone(logic [FreqBits-1:0] freq, logic [TimbreBits-1:0] amount);
    longint w;
    longint d;
    longint d2;
    longint d4;
    longint b;
    longint arg;
    longint z0;
    longint o;
    longint c376;
    longint wterm;
    longint sum;
    longint gain;
    w     = longint'(freq);
    phase = (phase + w) & 64'hFF_FFFF;
    d     = 64'sd8388608 - w;
    d2    = (d * d) >>> 24;
    d4    = (d2 * d2) >>> 24;
    b     = (13 * d4 * longint'(amount)) >>> 16;
    arg   = 2 * phase - 64'sd16777216 + ((b * feedback_now) >>> FracBits);
    z0    = clamp((feedback_now + sine_of(arg)) >>> 1);
    feedback_now = z0;
    o     = (5 * z0 - 3 * feedback_prev) >>> 1;
    feedback_prev = z0;
    c376  = ((64'sd376 <<< FracBits) + 500) / 1000;
    wterm = ((752 * w) <<< FracBits) / (64'sd1000 <<< 24);
    sum   = o + c376 - wterm;
    gain  = 64'sd16777216 - 2 * w;
    pending_samples.push_back(SampleBits'(clamp((sum * gain) >>> 24)));
  endfunction

  task report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task check_sample(logic signed [SampleBits-1:0] got);
    logic signed [SampleBits-1:0] want;
    if (pending_samples.size() == 0) begin
      report_mismatch($sformatf("sample %0d arrived with none pending", got));
    end else begin
      want = pending_samples.pop_front();
      if (got !== want) begin
        report_mismatch($sformatf("sample #%0d is %0d, predicted %0d",
                                  samples_checked, got, want));
      end
    end
    samples_checked++;
  endtask

endclass

module quasi_bandlimited_saw_osc_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ToneItems  = 1500;
  localparam int HoldCycles = 400;
  localparam int StallLimit = 5000;
  localparam int DrainWait  = 100;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [FreqBits-1:0]          norm_freq_i;
  logic [TimbreBits-1:0]        timbre_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic signed [SampleBits-1:0] sample_o;

  sample_scoreboard board;
  int items_sent;
  int samples_seen;
  int quiet_cycles;

  logic [FreqBits-1:0] corner_freq [20] = '{
    24'd0, 24'd0, 24'd1, 24'd8388608, 24'd8388607, 24'd8388609, 24'd16777215,
    24'd16777215, 24'd12582912, 24'd4194304, 24'd4194304, 24'd4194304,
    24'd2796203, 24'd699051, 24'd100, 24'd100, 24'd11184811, 24'd1398101,
    24'd16777214, 24'd0
  };
  logic [TimbreBits-1:0] corner_timbre [20] = '{
    17'd0, 17'd65536, 17'd65536, 17'd65536, 17'd0, 17'd65536, 17'd131071,
    17'd0, 17'd65536, 17'd131071, 17'd131071, 17'd131071,
    17'd65536, 17'd65536, 17'd65536, 17'd131071, 17'd98304, 17'd32768,
    17'd1, 17'd131071
  };

  quasi_bandlimited_saw_osc u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .norm_freq_i (norm_freq_i),
    .timbre_i    (timbre_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_tone(input logic [FreqBits-1:0] freq,
                           input logic [TimbreBits-1:0] amount);
    in_valid_i  <= 1'b1;
    norm_freq_i <= freq;
    timbre_i    <= amount;
    do @(posedge clk_i); while (!in_ready_o);
    board.accept_tone(freq, amount);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [FreqBits-1:0]   freq;
    logic [TimbreBits-1:0] amount;
    int kind;
    int count;
    int burst_left;
    int gap;
    bit steady;
    board       = new();
    items_sent  = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    norm_freq_i = '0;
    timbre_i    = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 20; i++) begin
      send_tone(corner_freq[i], corner_timbre[i]);
    end

    burst_left = 0;
    while (items_sent < ToneItems) begin
      kind   = $urandom_range(0, 9);
      steady = ($urandom_range(0, 3) == 0);
      if (kind <= 6) begin
        freq   = FreqBits'($urandom_range(0, 8388608));
        amount = TimbreBits'($urandom_range(0, 65536));
        count  = $urandom_range(4, 60);
      end else if (kind == 7) begin
        freq   = FreqBits'($urandom());
        amount = TimbreBits'($urandom());
        count  = $urandom_range(1, 10);
      end else if (kind == 8) begin
        count  = $urandom_range(1, 20);
      end else begin
        freq   = FreqBits'($urandom_range(0, 2000));
        amount = TimbreBits'($urandom_range(0, 65536));
        count  = $urandom_range(10, 60);
      end
      for (int n = 0; n < count; n++) begin
        if (kind == 8) begin
          freq   = FreqBits'($urandom());
          amount = TimbreBits'($urandom());
        end
        if (!steady && burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap = $urandom_range(0, 40);
          if (gap > 0) pause_sender(gap);
        end
        if (burst_left > 0) burst_left--;
        send_tone(freq, amount);
      end
    end

    in_valid_i <= 1'b0;
    while (board.pending_samples.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int mode;
    int span_left;
    int holds_done;
    out_ready_i = 1'b0;
    mode        = 0;
    span_left   = 0;
    holds_done  = 0;
    forever begin
      @(negedge clk_i);
      if (holds_done < 2 && samples_seen >= (holds_done == 0 ? 60 : 800)) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        holds_done++;
      end
      if (span_left == 0) begin
        mode      = $urandom_range(0, 2);
        span_left = $urandom_range(16, 256);
      end
      span_left--;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial samples_seen = 0;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_sample(sample_o);
      samples_seen++;
    end
  end

  initial quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
